// ===== rtl/prefix_code_bit_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// prefix code bit decoder assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PREFIX_CODE_BIT_DECODER_TOP_MACROS_SVH
`define PREFIX_CODE_BIT_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define PCBD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcbd_pkg
// widths, function codes and shared types of the prefix code bit decoder
// ----------------------------------------------------------------------------
package pcbd_pkg;

    localparam int SYMBOL_W         = 8;
    localparam int INDEX_W          = 8;
    localparam int ENTRY_LEN_W      = 6;
    localparam int ENTRY_CODE_W     = 32;
    localparam int COUNT_W          = 9;
    localparam int DEF_MAX_ENTRIES  = 256;
    localparam int DEF_MAX_CODE_LEN = 32;
    localparam int SEG_CELLS        = 8;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    // priority link between neighboring cells
    typedef struct packed {
        logic                hit;
        logic [SYMBOL_W-1:0] symbol;
    } link_t;

    // table entry write broadcast to the cell row
    typedef struct packed {
        logic                    en;
        logic [INDEX_W-1:0]      index;
        logic [SYMBOL_W-1:0]     symbol;
        logic [ENTRY_LEN_W-1:0]  length;
        logic [ENTRY_CODE_W-1:0] code;
        logic                    good;
    } entry_wr_t;

    // capture request from the accumulator into the result stages
    typedef struct packed {
        logic load;
        logic err;
    } capture_t;

endpackage

// ===== rtl/pcbd_in_if.sv =====
// ----------------------------------------------------------------------------
// pcbd_in_if
// input channel: table entry writes and coded bits
// ----------------------------------------------------------------------------
interface pcbd_in_if;
    import pcbd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [INDEX_W-1:0]      entry_index;
    logic [SYMBOL_W-1:0]     entry_symbol;
    logic [ENTRY_LEN_W-1:0]  entry_length;
    logic [ENTRY_CODE_W-1:0] entry_code;
    logic                    code_bit;

    modport source (
        output valid, func, entry_index, entry_symbol, entry_length, entry_code, code_bit,
        input  ready
    );

    modport sink (
        input  valid, func, entry_index, entry_symbol, entry_length, entry_code, code_bit,
        output ready
    );

endinterface

// ===== rtl/pcbd_out_if.sv =====
// ----------------------------------------------------------------------------
// pcbd_out_if
// output channel: decoded symbols and error flags
// ----------------------------------------------------------------------------
interface pcbd_out_if;
    import pcbd_pkg::*;

    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    logic                code_error;

    modport source (
        output valid, symbol, code_error,
        input  ready
    );

    modport sink (
        input  valid, symbol, code_error,
        output ready
    );

endinterface

// ===== rtl/pcbd_cell.sv =====
// ----------------------------------------------------------------------------
// pcbd_cell
// one code table entry with its match logic and priority link
// ----------------------------------------------------------------------------
module pcbd_cell #(
    parameter int INDEX = 0,
    parameter int CMP_W = 32,
    parameter int CL_W  = 6
) (
    input  logic                       clk,
    input  pcbd_pkg::entry_wr_t        wr,
    input  logic [pcbd_pkg::COUNT_W-1:0] entry_count,
    input  logic [CMP_W-1:0]           acc_cmp,
    input  logic [CL_W-1:0]            acc_len_cmp,
    input  pcbd_pkg::link_t            link_in,
    output pcbd_pkg::link_t            link_out
);
    import pcbd_pkg::*;

    logic [SYMBOL_W-1:0]     symbol_reg;
    logic [ENTRY_LEN_W-1:0]  length_reg;
    logic [ENTRY_CODE_W-1:0] code_reg;
    logic                    good_reg;
    logic                    active;
    logic                    hit;

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.index == INDEX_W'(INDEX)))
        begin
            symbol_reg <= wr.symbol;
            length_reg <= wr.length;
            code_reg   <= wr.code;
            good_reg   <= wr.good;
        end
    end

    assign active = entry_count > COUNT_W'(INDEX);
    assign hit    = active && good_reg
                    && (CL_W'(length_reg) == acc_len_cmp)
                    && (CMP_W'(code_reg) == acc_cmp);

    always_comb
    begin
        if (link_in.hit)
            link_out = link_in;
        else if (hit)
            link_out = '{hit: 1'b1, symbol: symbol_reg};
        else
            link_out = link_in;
    end

endmodule

// ===== rtl/pcbd_resolve.sv =====
// ----------------------------------------------------------------------------
// pcbd_resolve
// captures segment results, picks the lowest hit and holds the output word
// ----------------------------------------------------------------------------
module pcbd_resolve #(
    parameter int NSEG = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pcbd_pkg::capture_t           cap,
    input  pcbd_pkg::link_t [NSEG-1:0]   seg_res,
    output logic                         cap_ready,
    pcbd_out_if.source                   sym_out
);
    import pcbd_pkg::*;

    logic                s1_valid_reg, s1_valid_next;
    logic                s1_err_reg;
    link_t [NSEG-1:0]    s1_seg_reg;
    logic                out_valid_reg, out_valid_next;
    logic [SYMBOL_W-1:0] out_symbol_reg;
    logic                out_error_reg;
    logic                out_load;
    logic                do_load;
    logic [NSEG-1:0]     lower_hit;
    logic [SYMBOL_W-1:0] pick_symbol;

    assign out_load  = s1_valid_reg && (!out_valid_reg || sym_out.ready);
    assign cap_ready = !s1_valid_reg || out_load;
    assign do_load   = cap.load && cap_ready;

    always_comb
    begin
        for (int k = 0; k < NSEG; k++)
        begin
            lower_hit[k] = 1'b0;
            for (int j = 0; j < k; j++)
                lower_hit[k] = lower_hit[k] | s1_seg_reg[j].hit;
        end
    end

    always_comb
    begin
        pick_symbol = '0;
        for (int k = 0; k < NSEG; k++)
        begin
            if (s1_seg_reg[k].hit && !lower_hit[k])
                pick_symbol = pick_symbol | s1_seg_reg[k].symbol;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (do_load)
            s1_valid_next = 1'b1;
        else if (out_load)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (sym_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            s1_seg_reg <= seg_res;
            s1_err_reg <= cap.err;
        end
        if (out_load)
        begin
            out_symbol_reg <= s1_err_reg ? '0 : pick_symbol;
            out_error_reg  <= s1_err_reg;
        end
    end

    assign sym_out.valid      = out_valid_reg;
    assign sym_out.symbol     = out_symbol_reg;
    assign sym_out.code_error = out_error_reg;

endmodule

// ===== rtl/prefix_code_bit_decoder_top.sv =====
// ----------------------------------------------------------------------------
// prefix_code_bit_decoder_top
// prefix code decoder over a row of table cells with, while ready, one bit per cycle
// ----------------------------------------------------------------------------
// code_in carries words of two kinds: func write stores entry_symbol,
// entry_length and entry_code at entry_index; func decode shifts code_bit
// into the accumulator. cfg_wr_en/cfg_wr_data set entry_count, to be written
// by the user only while the block is idle; the block does not enforce this.
// sym_out carries one word per finished code: the symbol, or code_error with
// a zero symbol when MAX_CODE_LEN bits gather with no hit.
// Every cell compares the accumulator against its entry in parallel; the
// lowest hit wins through an eight-cell priority link inside each segment
// and a registered select across segments.
// Throughput: one word per cycle while ready is high, set by the accumulator
// loop (shift, cell compare, segment link, hit reduction, clear). A result goes
// from the capture stage into the output register, which drives sym_out.
// Reset clears the accumulator, entry_count and the result stages; table
// entries are undefined until written. When sym_out stalls, the capture
// stage and the output register hold, and ready drops once both are full.
// ----------------------------------------------------------------------------
`include "prefix_code_bit_decoder_top_macros.svh"

module prefix_code_bit_decoder_top #(
    parameter int MAX_ENTRIES  = pcbd_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_CODE_LEN = pcbd_pkg::DEF_MAX_CODE_LEN
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [pcbd_pkg::COUNT_W-1:0]   cfg_wr_data,
    pcbd_in_if.sink                        code_in,
    pcbd_out_if.source                     sym_out
);
    import pcbd_pkg::*;

    localparam int ACC_W = MAX_CODE_LEN;
    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
    localparam int CMP_W = (ACC_W > ENTRY_CODE_W) ? ACC_W : ENTRY_CODE_W;
    localparam int CL_W  = (LEN_W > ENTRY_LEN_W) ? LEN_W : ENTRY_LEN_W;
    localparam int GL_W  = ENTRY_LEN_W + 1;
    localparam int NSEG  = (MAX_ENTRIES + SEG_CELLS - 1) / SEG_CELLS;

    logic [COUNT_W-1:0]      entry_count_reg;
    logic [ACC_W-1:0]        acc_bits_reg, acc_bits_next;
    logic [LEN_W-1:0]        acc_len_reg, acc_len_next;
    logic [ACC_W-1:0]        acc_shift;
    logic [LEN_W-1:0]        acc_len_step;
    logic [ENTRY_CODE_W-1:0] code_mask;
    entry_wr_t               wr;
    link_t                   chain [MAX_ENTRIES];
    link_t [NSEG-1:0]        seg_res;
    logic [NSEG-1:0]         seg_hit;
    logic                    any_hit;
    logic                    err_now;
    logic                    result_now;
    logic                    accept;
    logic                    dec_accept;
    logic                    wr_accept;
    logic                    cap_ready;
    capture_t                cap;

    assign accept     = code_in.valid && code_in.ready;
    assign dec_accept = accept && (code_in.func == FUNC_DECODE);
    assign wr_accept  = accept && (code_in.func == FUNC_WRITE);
    assign code_in.ready = cap_ready;

    // entry write with the code trimmed to its length
    assign code_mask = (code_in.entry_length >= ENTRY_LEN_W'(ENTRY_CODE_W))
                       ? '1
                       : ((ENTRY_CODE_W'(1) << code_in.entry_length) - ENTRY_CODE_W'(1));

    always_comb
    begin
        wr.en     = wr_accept;
        wr.index  = code_in.entry_index;
        wr.symbol = code_in.entry_symbol;
        wr.length = code_in.entry_length;
        wr.code   = code_in.entry_code & code_mask;
        wr.good   = (code_in.entry_length != '0)
                    && (GL_W'(code_in.entry_length) <= GL_W'(MAX_CODE_LEN));
    end

    assign acc_shift    = {acc_bits_reg[ACC_W-2:0], code_in.code_bit};
    assign acc_len_step = acc_len_reg + LEN_W'(1);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            localparam int POS = gi % SEG_CELLS;
            link_t link_in;

            if (POS == 0)
            begin : g_head
                assign link_in = '0;
            end
            else
            begin : g_body
                assign link_in = chain[gi-1];
            end

            pcbd_cell #(
                .INDEX (gi),
                .CMP_W (CMP_W),
                .CL_W  (CL_W)
            ) u_cell (
                .clk         (clk),
                .wr          (wr),
                .entry_count (entry_count_reg),
                .acc_cmp     (CMP_W'(acc_shift)),
                .acc_len_cmp (CL_W'(acc_len_step)),
                .link_in     (link_in),
                .link_out    (chain[gi])
            );
        end

        for (gi = 0; gi < NSEG; gi++)
        begin : g_seg
            localparam int LAST = (((gi + 1) * SEG_CELLS) < MAX_ENTRIES)
                                  ? ((gi + 1) * SEG_CELLS - 1) : (MAX_ENTRIES - 1);
            assign seg_res[gi] = chain[LAST];
            assign seg_hit[gi] = chain[LAST].hit;
        end
    endgenerate

    assign any_hit    = |seg_hit;
    assign err_now    = !any_hit && (acc_len_step == LEN_W'(MAX_CODE_LEN));
    assign result_now = any_hit || err_now;

    always_comb
    begin
        cap.load = code_in.valid && (code_in.func == FUNC_DECODE) && result_now;
        cap.err  = err_now;
    end

    always_comb
    begin
        acc_bits_next = acc_bits_reg;
        acc_len_next  = acc_len_reg;
        if (dec_accept)
        begin
            if (result_now)
            begin
                acc_bits_next = '0;
                acc_len_next  = '0;
            end
            else
            begin
                acc_bits_next = acc_shift;
                acc_len_next  = acc_len_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            acc_bits_reg    <= '0;
            acc_len_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                entry_count_reg <= cfg_wr_data;
            acc_bits_reg <= acc_bits_next;
            acc_len_reg  <= acc_len_next;
        end
    end

    pcbd_resolve #(
        .NSEG (NSEG)
    ) u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap),
        .seg_res   (seg_res),
        .cap_ready (cap_ready),
        .sym_out   (sym_out)
    );

    `PCBD_ASSERT_IMPLIES(a_acc_len_range, 1'b1, acc_len_reg < LEN_W'(MAX_CODE_LEN),
        "accumulator length reached the maximum code length")
    `PCBD_ASSERT_NEXT(a_clear_after_code, dec_accept && result_now,
        (acc_len_reg == '0) && (acc_bits_reg == '0),
        "accumulator not cleared after a finished code")
    `PCBD_ASSERT_NEXT(a_write_keeps_acc, wr_accept,
        $stable(acc_len_reg) && $stable(acc_bits_reg),
        "table write disturbed the accumulator")
    `PCBD_ASSERT_IMPLIES(a_error_symbol_zero, sym_out.valid && sym_out.code_error,
        sym_out.symbol == '0, "error word carries a nonzero symbol")

endmodule
